// File: hdl/drfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drfl_pkg
// Shared types and constants of the descriptor ring free list.
// ----------------------------------------------------------------------------
package drfl_pkg;

	localparam int RING_SIZE = 256;
	localparam int IDX_W     = $clog2(RING_SIZE);
	localparam int LINK_W    = 16;
	localparam int CNT_W     = IDX_W + 1;
	localparam int LG_W      = 4;
	localparam int CMD_W     = 3;

	localparam logic [LINK_W-1:0] LIST_END = 16'hffff;
	localparam logic [LG_W-1:0]   LG_RESET = 4'd8;
	localparam logic [LG_W-1:0]   LG_MAX   = LG_W'(IDX_W);

	localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FREE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SUBMIT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [IDX_W-1:0] entry_idx;
		logic [CNT_W-1:0] chain_length;
	} req_t;

	typedef struct packed {
		logic              status;
		logic [IDX_W-1:0]  chain_start;
		logic [CNT_W-1:0]  free_total;
		logic [LINK_W-1:0] avail_position;
		logic [LINK_W-1:0] read_link;
		logic              read_has_next;
		logic [LINK_W-1:0] read_ring_entry;
	} rsp_t;

	typedef struct packed {
		logic              re;
		logic [IDX_W-1:0]  raddr;
		logic              link_we;
		logic              flag_we;
		logic              avail_we;
		logic [IDX_W-1:0]  waddr;
		logic [LINK_W-1:0] link_wdata;
		logic              flag_wdata;
		logic [LINK_W-1:0] avail_wdata;
	} mem_req_t;

	typedef struct packed {
		logic [LINK_W-1:0] link;
		logic              flag;
		logic [LINK_W-1:0] avail;
	} mem_rsp_t;

endpackage
`default_nettype wire

// File: hdl/drfl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drfl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module drfl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/drfl_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drfl_engine
// Command sequencer: free list head, counters, table sweeps and chain pops.
// ----------------------------------------------------------------------------
module drfl_engine (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire drfl_pkg::req_t                 req,
	input  wire logic [drfl_pkg::LG_W-1:0]      ring_lg,
	input  wire drfl_pkg::mem_rsp_t             mrsp,
	output drfl_pkg::mem_req_t                  mreq,
	output logic                                busy,
	output logic                                done,
	output drfl_pkg::rsp_t                      rsp
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_INIT   = 6'b000100,
		ST_POP_RD = 6'b001000,
		ST_POP_WR = 6'b010000,
		ST_READ   = 6'b100000
	} state_t;

	state_t                          state_q, state_d;
	logic [drfl_pkg::IDX_W-1:0]      sweep_q, sweep_d;
	logic [drfl_pkg::LINK_W-1:0]     head_q, head_d;
	logic [drfl_pkg::CNT_W-1:0]      count_q, count_d;
	logic [drfl_pkg::LINK_W-1:0]     avail_q, avail_d;
	logic [drfl_pkg::CNT_W-1:0]      remain_q, remain_d;
	logic [drfl_pkg::IDX_W-1:0]      last_q, last_d;
	logic                            first_q, first_d;
	logic                            done_q, done_d;
	drfl_pkg::rsp_t                  res_q, res_d;

	logic [drfl_pkg::LG_W-1:0]       lg_eff;
	logic [drfl_pkg::CNT_W-1:0]      n;
	logic [drfl_pkg::IDX_W-1:0]      mask;
	logic [drfl_pkg::IDX_W-1:0]      didx_m;
	logic                            stat;
	logic [drfl_pkg::IDX_W-1:0]      start_idx;
	logic [drfl_pkg::LINK_W-1:0]     r_link;
	logic                            r_flag;
	logic [drfl_pkg::LINK_W-1:0]     r_ring;

	always_comb begin
		if (ring_lg == '0) begin
			lg_eff = drfl_pkg::LG_W'(1);
		end else if (ring_lg > drfl_pkg::LG_MAX) begin
			lg_eff = drfl_pkg::LG_MAX;
		end else begin
			lg_eff = ring_lg;
		end
	end

	assign n      = drfl_pkg::CNT_W'(1) << lg_eff;
	assign mask   = drfl_pkg::IDX_W'(n - 1'b1);
	assign didx_m = req.entry_idx & mask;

	always_comb begin
		state_d   = state_q;
		sweep_d   = sweep_q;
		head_d    = head_q;
		count_d   = count_q;
		avail_d   = avail_q;
		remain_d  = remain_q;
		last_d    = last_q;
		first_d   = first_q;
		done_d    = 1'b0;
		mreq      = '0;
		stat      = 1'b0;
		start_idx = '0;
		r_link    = '0;
		r_flag    = 1'b0;
		r_ring    = '0;

		case (state_q)
			ST_CLEAR: begin
				mreq.flag_we = 1'b1;
				mreq.waddr   = sweep_q;
				sweep_d      = sweep_q + 1'b1;
				if (sweep_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (req.command)
						drfl_pkg::CMD_INIT: begin
							sweep_d = '0;
							state_d = ST_INIT;
						end
						drfl_pkg::CMD_FREE: begin
							mreq.link_we    = 1'b1;
							mreq.waddr      = didx_m;
							mreq.link_wdata = head_q;
							head_d          = drfl_pkg::LINK_W'(didx_m);
							if (count_q < n) begin
								count_d = count_q + 1'b1;
							end
							done_d = 1'b1;
						end
						drfl_pkg::CMD_ALLOC: begin
							if (req.chain_length == '0 || count_q < req.chain_length) begin
								stat   = 1'b1;
								done_d = 1'b1;
							end else begin
								remain_d = req.chain_length;
								first_d  = 1'b1;
								state_d  = ST_POP_RD;
							end
						end
						drfl_pkg::CMD_SUBMIT: begin
							mreq.avail_we    = 1'b1;
							mreq.waddr       = avail_q[drfl_pkg::IDX_W-1:0] & mask;
							mreq.avail_wdata = drfl_pkg::LINK_W'(didx_m);
							avail_d          = avail_q + 1'b1;
							done_d           = 1'b1;
						end
						drfl_pkg::CMD_READ: begin
							mreq.re    = 1'b1;
							mreq.raddr = didx_m;
							state_d    = ST_READ;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_INIT: begin
				mreq.link_we  = 1'b1;
				mreq.flag_we  = 1'b1;
				mreq.avail_we = 1'b1;
				mreq.waddr    = sweep_q;
				if (sweep_q == '0) begin
					mreq.link_wdata = drfl_pkg::LIST_END;
				end else if (drfl_pkg::CNT_W'(sweep_q) < n) begin
					mreq.link_wdata = drfl_pkg::LINK_W'(sweep_q - 1'b1);
				end
				sweep_d = sweep_q + 1'b1;
				if (sweep_q == '1) begin
					head_d  = drfl_pkg::LINK_W'(n - 1'b1);
					count_d = n;
					avail_d = '0;
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_POP_RD: begin
				if (head_q >= drfl_pkg::LINK_W'(n)) begin
					stat    = 1'b1;
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					mreq.re    = 1'b1;
					mreq.raddr = head_q[drfl_pkg::IDX_W-1:0];
					state_d    = ST_POP_WR;
				end
			end
			ST_POP_WR: begin
				mreq.link_we    = 1'b1;
				mreq.flag_we    = 1'b1;
				mreq.waddr      = head_q[drfl_pkg::IDX_W-1:0];
				mreq.link_wdata = first_q ? '0 : drfl_pkg::LINK_W'(last_q);
				mreq.flag_wdata = !first_q;
				head_d          = mrsp.link;
				count_d         = count_q - 1'b1;
				last_d          = head_q[drfl_pkg::IDX_W-1:0];
				first_d         = 1'b0;
				remain_d        = remain_q - 1'b1;
				if (remain_q == drfl_pkg::CNT_W'(1)) begin
					start_idx = head_q[drfl_pkg::IDX_W-1:0];
					done_d    = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_POP_RD;
				end
			end
			ST_READ: begin
				r_link  = mrsp.link;
				r_flag  = mrsp.flag;
				r_ring  = mrsp.avail;
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		res_d = res_q;
		if (done_d) begin
			res_d.status          = stat;
			res_d.chain_start     = start_idx;
			res_d.free_total      = count_d;
			res_d.avail_position  = avail_d;
			res_d.read_link       = r_link;
			res_d.read_has_next   = r_flag;
			res_d.read_ring_entry = r_ring;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			sweep_q  <= '0;
			head_q   <= drfl_pkg::LIST_END;
			count_q  <= '0;
			avail_q  <= '0;
			remain_q <= '0;
			first_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			sweep_q  <= sweep_d;
			head_q   <= head_d;
			count_q  <= count_d;
			avail_q  <= avail_d;
			remain_q <= remain_d;
			first_q  <= first_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		last_q <= last_d;
		res_q  <= res_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = res_q;

endmodule
`default_nettype wire

// File: hdl/descriptor_ring_free_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// descriptor_ring_free_list
// Descriptor table kept as a linked free list, plus an available ring.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on rsp for exactly one cycle with done high and must be captured
// then, since the block never waits for the receiver. Free, submit and
// unknown commands finish straight from idle, read waits for the registered
// RAM read, alloc pops each descriptor by reading its link, then rewriting
// its link and next flag, and init sweeps all 256 table entries. Busy drops
// in the cycle the result is shown, so the next command may be issued then.
// After reset the block stays busy while it clears the next-flag table;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module descriptor_ring_free_list (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire drfl_pkg::req_t                 req,
	output logic                                done,
	output drfl_pkg::rsp_t                      rsp,
	input  wire logic                           cfg_wr_en,
	input  wire logic [drfl_pkg::LG_W-1:0]      cfg_wr_data
);

	logic [drfl_pkg::LG_W-1:0] ring_lg_q;
	drfl_pkg::mem_req_t        mreq;
	drfl_pkg::mem_rsp_t        mrsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_lg_q <= drfl_pkg::LG_RESET;
		end else if (cfg_wr_en) begin
			ring_lg_q <= cfg_wr_data;
		end
	end

	drfl_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.ring_lg (ring_lg_q),
		.mrsp    (mrsp),
		.mreq    (mreq),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp)
	);

	drfl_ram #(
		.WIDTH (drfl_pkg::LINK_W),
		.DEPTH (drfl_pkg::RING_SIZE)
	) u_link_ram (
		.clk   (clk),
		.we    (mreq.link_we),
		.waddr (mreq.waddr),
		.wdata (mreq.link_wdata),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.rdata (mrsp.link)
	);

	drfl_ram #(
		.WIDTH (1),
		.DEPTH (drfl_pkg::RING_SIZE)
	) u_flag_ram (
		.clk   (clk),
		.we    (mreq.flag_we),
		.waddr (mreq.waddr),
		.wdata (mreq.flag_wdata),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.rdata (mrsp.flag)
	);

	drfl_ram #(
		.WIDTH (drfl_pkg::LINK_W),
		.DEPTH (drfl_pkg::RING_SIZE)
	) u_avail_ram (
		.clk   (clk),
		.we    (mreq.avail_we),
		.waddr (mreq.waddr),
		.wdata (mreq.avail_wdata),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.rdata (mrsp.avail)
	);

endmodule
`default_nettype wire

// File: hdl/drfl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drfl_checker
// Port-level checks of the descriptor ring free list, bound to the top level.
// ----------------------------------------------------------------------------
module drfl_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire drfl_pkg::req_t                 req,
	input wire logic                           done,
	input wire drfl_pkg::rsp_t                 rsp
);

	a_no_spurious_item: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !done)
		else $error("item reported with no command taken");

	a_free_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.command == drfl_pkg::CMD_FREE) |=> (done && !busy))
		else $error("free did not complete in one cycle");

	a_fail_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status) |-> (rsp.chain_start == '0 && rsp.read_link == '0))
		else $error("failed alloc reports a chain start");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.free_total <= drfl_pkg::CNT_W'(drfl_pkg::RING_SIZE)))
		else $error("free count above ring size");

endmodule

bind descriptor_ring_free_list drfl_checker u_drfl_checker (.*);
`default_nettype wire

// File: verif/tb_descriptor_ring_free_list.sv
// ----------------------------------------------------------------------------
// tb_descriptor_ring_free_list
// Drives init, free, alloc, submit, read and unused commands into the
// descriptor free list across several ring sizes, predicts every reply from a
// local copy of the tables, and compares each reply field by field.
// ----------------------------------------------------------------------------
module tb_descriptor_ring_free_list;

	import drfl_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	req_t                req;
	logic                done;
	rsp_t                rsp;
	logic                cfg_wr_en;
	logic [LG_W-1:0]     cfg_wr_data;

	logic [LINK_W-1:0]   link_mem [RING_SIZE];
	bit                  flag_mem [RING_SIZE];
	logic [LINK_W-1:0]   ring_mem [RING_SIZE];
	logic [LINK_W-1:0]   list_head;
	int                  free_cnt;
	logic [LINK_W-1:0]   avail_idx;
	logic [LG_W-1:0]     size_lg;
	int                  held_desc [$];

	rsp_t                replies_due [$];
	int                  send_idle_pct;
	int                  mismatches;

	descriptor_ring_free_list dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	function automatic int ring_count();
		int lg;
		int n;
		lg = (size_lg == 0) ? 1 : int'(size_lg);
		n = 1 << lg;
		return (n > RING_SIZE) ? RING_SIZE : n;
	endfunction

	function automatic rsp_t run_descriptor_cmd(req_t item);
		rsp_t r;
		int n;
		int i;
		int k;
		int h;
		int last;
		r = '0;
		n = ring_count();
		last = 0;
		case (item.command)
			CMD_INIT: begin
				for (i = 0; i < RING_SIZE; i++) begin
					link_mem[i] = (i >= n) ? '0 : (i == 0) ? LIST_END : LINK_W'(i - 1);
					flag_mem[i] = 1'b0;
					ring_mem[i] = '0;
				end
				list_head = LINK_W'(n - 1);
				free_cnt = n;
				avail_idx = '0;
				held_desc.delete();
			end
			CMD_FREE: begin
				i = int'(item.entry_idx) & (n - 1);
				link_mem[i] = list_head;
				list_head = LINK_W'(i);
				if (free_cnt < n)
					free_cnt++;
			end
			CMD_ALLOC: begin
				if (item.chain_length == 0 || free_cnt < int'(item.chain_length)) begin
					r.status = 1'b1;
				end else begin
					for (k = 0; k < int'(item.chain_length) && !r.status; k++) begin
						h = int'(list_head);
						if (h >= n) begin
							r.status = 1'b1;
						end else begin
							list_head = link_mem[h];
							free_cnt--;
							flag_mem[h] = (k != 0);
							link_mem[h] = (k == 0) ? '0 : LINK_W'(last);
							last = h;
							held_desc.push_back(h);
						end
					end
					if (!r.status)
						r.chain_start = IDX_W'(last);
				end
			end
			CMD_SUBMIT: begin
				ring_mem[int'(avail_idx) & (n - 1)] = LINK_W'(int'(item.entry_idx) & (n - 1));
				avail_idx = avail_idx + 1'b1;
			end
			CMD_READ: begin
				i = int'(item.entry_idx) & (n - 1);
				r.read_link = link_mem[i];
				r.read_has_next = flag_mem[i];
				r.read_ring_entry = ring_mem[i];
			end
			default: begin
			end
		endcase
		r.free_total = CNT_W'(free_cnt);
		r.avail_position = avail_idx;
		return r;
	endfunction

	function automatic void check_field(string name, logic [LINK_W-1:0] want,
			logic [LINK_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (done === 1'b1) begin
			if (replies_due.size() == 0) begin
				$error("reply with no command outstanding");
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				check_field("status", LINK_W'(want.status), LINK_W'(rsp.status));
				check_field("chain_start", LINK_W'(want.chain_start), LINK_W'(rsp.chain_start));
				check_field("free_total", LINK_W'(want.free_total), LINK_W'(rsp.free_total));
				check_field("avail_position", want.avail_position, rsp.avail_position);
				check_field("read_link", want.read_link, rsp.read_link);
				check_field("read_has_next", LINK_W'(want.read_has_next),
					LINK_W'(rsp.read_has_next));
				check_field("read_ring_entry", want.read_ring_entry, rsp.read_ring_entry);
			end
		end
	end

	task automatic issue_cmd(req_t item);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy !== 1'b0);
		replies_due.push_back(run_descriptor_cmd(item));
	endtask

	task automatic send(logic [CMD_W-1:0] cmd, int idx, int len);
		req_t item;
		item.command = cmd;
		item.entry_idx = IDX_W'(idx);
		item.chain_length = CNT_W'(len);
		issue_cmd(item);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (replies_due.size() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	task automatic set_ring_size(logic [LG_W-1:0] lg);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lg;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		size_lg = lg;
	endtask

	task automatic test_pre_init();
		send(CMD_ALLOC, 0, 1);
		send(CMD_ALLOC, 0, 0);
		send(CMD_SUBMIT, 255, 0);
		send(CMD_UNUSED, 255, 511);
	endtask

	task automatic test_full_ring();
		send(CMD_INIT, 0, 0);
		send(CMD_READ, 255, 0);
		send(CMD_FREE, 7, 0);
		send(CMD_ALLOC, 0, 256);
		send(CMD_ALLOC, 0, 511);
		send(CMD_READ, 7, 0);
		send(CMD_SUBMIT, 255, 0);
		send(CMD_READ, 0, 0);
	endtask

	task automatic test_ring_sizes();
		wait_idle();
		set_ring_size(4'd0);
		send(CMD_INIT, 0, 0);
		send(CMD_ALLOC, 0, 2);
		send(CMD_READ, 255, 0);
		send(CMD_SUBMIT, 255, 0);
		send(CMD_SUBMIT, 254, 0);
		send(CMD_READ, 1, 0);
		wait_idle();
		set_ring_size(4'd15);
		send(CMD_INIT, 0, 0);
		send(CMD_READ, 255, 0);
	endtask

	task automatic test_broken_list();
		wait_idle();
		set_ring_size(4'd3);
		send(CMD_INIT, 0, 0);
		wait_idle();
		set_ring_size(4'd2);
		send(CMD_FREE, 2, 0);
		send(CMD_ALLOC, 0, 2);
		send(CMD_READ, 2, 0);
	endtask

	task automatic test_mixed_traffic(int idle_pct, logic [LG_W-1:0] lg, int count);
		req_t item;
		int pick;
		int sel;
		wait_idle();
		set_ring_size(lg);
		send_idle_pct = idle_pct;
		send(CMD_INIT, 0, 0);
		repeat (count) begin
			item.entry_idx = IDX_W'($urandom);
			item.chain_length = CNT_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				item.command = CMD_INIT;
			end else if (pick < 28) begin
				item.command = CMD_FREE;
				if (held_desc.size() != 0 && $urandom_range(0, 3) != 0) begin
					sel = $urandom_range(0, held_desc.size() - 1);
					item.entry_idx = IDX_W'(held_desc[sel]);
					held_desc.delete(sel);
				end
			end else if (pick < 55) begin
				item.command = CMD_ALLOC;
				pick = $urandom_range(0, 19);
				if (pick == 0)
					item.chain_length = '0;
				else if (pick == 1)
					item.chain_length = CNT_W'($urandom_range(free_cnt + 1, 511));
				else if (pick == 2)
					item.chain_length = CNT_W'($urandom_range(1, RING_SIZE));
				else
					item.chain_length = CNT_W'($urandom_range(1,
						(free_cnt < 1) ? 1 : (free_cnt > 6) ? 6 : free_cnt));
			end else if (pick < 70) begin
				item.command = CMD_SUBMIT;
			end else if (pick < 94) begin
				item.command = CMD_READ;
			end else begin
				item.command = CMD_READ + CMD_W'($urandom_range(1, 3));
			end
			issue_cmd(item);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		foreach (link_mem[i]) begin
			link_mem[i] = '0;
			flag_mem[i] = 1'b0;
			ring_mem[i] = '0;
		end
		list_head = LIST_END;
		free_cnt = 0;
		avail_idx = '0;
		size_lg = LG_RESET;
		send_idle_pct = 0;
		mismatches = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_pre_init();
		test_full_ring();
		test_ring_sizes();
		test_broken_list();
		test_mixed_traffic(38, 4'd3, 375);
		test_mixed_traffic(64, LG_W'($urandom_range(1, 8)), 375);
		test_mixed_traffic(0, LG_RESET, 375);

		wait_idle();
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
